>>> src/pid_tbl_pkg.sv
// Shared types and constants for the process id table.
// No dependencies; imported by every module of the block.
`default_nettype none

package pid_tbl_pkg;

  localparam int unsigned DEF_MAX_PID = 255;
  localparam int unsigned DEF_MIN_PID = 2;
  localparam int unsigned TABLE_DEPTH = 256;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_WAIT   = 2'd1,
    OP_EXIT   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    RS_OK         = 3'd0,
    RS_FULL       = 3'd1,
    RS_NOPROC     = 3'd2,
    RS_NOTCHILD   = 3'd3,
    RS_NOTEXITED  = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the input word, start the entry read
    logic commit;  // update the table and load the result register
  } cmd_t;

  // One table entry besides its used flag.
  typedef struct packed {
    logic        exited;
    logic [7:0]  parent;
    logic [31:0] status;
  } entry_t;

endpackage

`default_nettype wire

>>> src/process_id_table.sv
// Top level of the process id table: controller plus datapath.
// Depends on pid_tbl_pkg, pid_tbl_ctrl and pid_tbl_dp.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   in_operation, in_target_pid, in_parent_pid, in_exit_code
//   out      out_valid / out_stall out_result_status, out_new_pid, out_child_status
//
// A word is taken as the entry memory and the first level of the free-id
// search tree are read; the execute state then decides, writes back and loads
// the result. A new word is taken in the idle state that follows that load.
// Reset clears all used flags at once; no clearing pass.
// A stalled result holds the finished word in its last cycle.
`default_nettype none

module process_id_table
  import pid_tbl_pkg::*;
#(
  parameter int unsigned MAX_PID = DEF_MAX_PID,
  parameter int unsigned MIN_PID = DEF_MIN_PID
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_operation,
  input  wire logic [7:0]         in_target_pid,
  input  wire logic [7:0]         in_parent_pid,
  input  wire logic signed [31:0] in_exit_code,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_result_status,
  output logic [7:0]              out_new_pid,
  output logic signed [31:0]      out_child_status
);

  cmd_t cmd;

  pid_tbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pid_tbl_dp #(
    .MAX_PID (MAX_PID),
    .MIN_PID (MIN_PID)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_operation),
    .in_target_pid     (in_target_pid),
    .in_parent_pid     (in_parent_pid),
    .in_exit_code      (in_exit_code),
    .out_result_status (out_result_status),
    .out_new_pid       (out_new_pid),
    .out_child_status  (out_child_status)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous word still in work");

  a_pid_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_new_pid != 8'd0) |-> (out_result_status == RS_OK))
    else $error("new pid reported without ok status");

  a_child_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_child_status != 32'sd0) |->
      (out_result_status == RS_OK && out_new_pid == 8'd0))
    else $error("child status reported outside a successful wait");
`endif

endmodule

`default_nettype wire

>>> src/pid_tbl_ctrl.sv
// Controller state machine of the process id table: handshakes and sequencing.
// Depends on pid_tbl_pkg.
`default_nettype none

module pid_tbl_ctrl
  import pid_tbl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold the finished word until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.commit || (out_valid_r && out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> src/pid_tbl_dp.sv
// Datapath of the process id table: used flags, entry memory, free-id search
// and result register. Depends on pid_tbl_pkg; driven by pid_tbl_ctrl.
`default_nettype none

module pid_tbl_dp
  import pid_tbl_pkg::*;
#(
  parameter int unsigned MAX_PID = DEF_MAX_PID,
  parameter int unsigned MIN_PID = DEF_MIN_PID
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  input  wire logic [1:0]         in_operation,
  input  wire logic [7:0]         in_target_pid,
  input  wire logic [7:0]         in_parent_pid,
  input  wire logic signed [31:0] in_exit_code,
  output logic [2:0]              out_result_status,
  output logic [7:0]              out_new_pid,
  output logic signed [31:0]      out_child_status
);

  localparam int unsigned TOP_ID  = (MAX_PID > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : MAX_PID;
  localparam logic [7:0]  TOP_ID8 = 8'(TOP_ID);
  localparam logic [7:0]  MIN_ID8 = 8'(MIN_PID);

  function automatic logic [2:0] lowest8(input logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  // captured input word
  logic [1:0]  op_r;
  logic [7:0]  tgt_r;
  logic [7:0]  par_r;
  logic [31:0] code_r;

  // table state
  logic [255:0] used_r, used_nxt;
  entry_t       mem [TABLE_DEPTH];
  entry_t       rd_r;
  logic         we;
  logic [7:0]   wa;
  entry_t       wd;

  // free-id search tree: 64-id quarters, 8-id bytes
  logic [255:0] free_vec;
  logic [31:0]  byte_free_r;
  logic [3:0]   quad_free_r;
  logic [1:0]   q_sel;
  logic [2:0]   b_sel;
  logic [2:0]   k_sel;
  logic [7:0]   found_id;

  // result
  logic [2:0]  res_status;
  logic [7:0]  res_pid;
  logic [31:0] res_child;
  logic [2:0]  status_r;
  logic [7:0]  pid_r;
  logic [31:0] child_r;

  logic tgt_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      tgt_r  <= in_target_pid;
      par_r  <= in_parent_pid;
      code_r <= $unsigned(in_exit_code);
      rd_r   <= mem[in_target_pid];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_comb begin
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      free_vec[i] = !used_r[i] && (i >= MIN_PID) && (i <= TOP_ID);
    end
  end

  // first level of the search, refreshed every cycle
  always_ff @(posedge clk) begin
    for (int b = 0; b < 32; b++) begin
      byte_free_r[b] <= |free_vec[b*8 +: 8];
    end
    for (int q = 0; q < 4; q++) begin
      quad_free_r[q] <= |free_vec[q*64 +: 64];
    end
  end

  always_comb begin
    q_sel    = 2'(lowest8({4'b0000, quad_free_r}));
    b_sel    = lowest8(byte_free_r[{q_sel, 3'b000} +: 8]);
    k_sel    = lowest8(free_vec[{q_sel, b_sel, 3'b000} +: 8]);
    found_id = {q_sel, b_sel, k_sel};
  end

  assign tgt_valid = (tgt_r >= MIN_ID8) && (tgt_r <= TOP_ID8) && used_r[tgt_r];

  always_comb begin
    res_status = RS_NOPROC;
    res_pid    = 8'd0;
    res_child  = 32'd0;
    used_nxt   = used_r;
    we         = 1'b0;
    wa         = tgt_r;
    wd         = rd_r;
    case (op_t'(op_r))
      OP_CREATE: begin
        if (|quad_free_r) begin
          res_status = RS_OK;
          res_pid    = found_id;
          wa         = found_id;
          wd.exited  = 1'b0;
          wd.parent  = par_r;
          wd.status  = 32'd0;
          if (cmd.commit) begin
            we                 = 1'b1;
            used_nxt[found_id] = 1'b1;
          end
        end else begin
          res_status = RS_FULL;
        end
      end
      OP_WAIT: begin
        if (!tgt_valid) begin
          res_status = RS_NOPROC;
        end else if (rd_r.parent != par_r) begin
          res_status = RS_NOTCHILD;
        end else if (!rd_r.exited) begin
          res_status = RS_NOTEXITED;
        end else begin
          res_status = RS_OK;
          res_child  = rd_r.status;
          if (cmd.commit) used_nxt[tgt_r] = 1'b0;
        end
      end
      OP_EXIT: begin
        if (tgt_valid) begin
          res_status = RS_OK;
          wd.exited  = 1'b1;
          wd.status  = code_r;
          we         = cmd.commit;
        end
      end
      default: res_status = RS_NOPROC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= res_status;
      pid_r    <= res_pid;
      child_r  <= res_child;
    end
  end

  assign out_result_status = status_r;
  assign out_new_pid       = pid_r;
  assign out_child_status  = $signed(child_r);

endmodule

`default_nettype wire
